### design/ttvp_pkg.sv
// shared types, constants and helper functions for the truth table variable permuter
package ttvp_pkg;

  localparam int NUM_VARS   = 6;
  localparam int PERM_COUNT = 720;

  localparam int TABLE_W    = 64;
  localparam int PERM_W     = 10;
  localparam int TABLE_BITS = 1 << NUM_VARS;
  localparam int VAR_W      = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int HALF_VARS  = NUM_VARS / 2;

  // reciprocal scaling, exact floor quotient for divisors up to 2^PERM_W
  localparam int RECIP_SHIFT = 2 * PERM_W;
  localparam int QUOT_W      = PERM_W + RECIP_SHIFT;

  typedef logic [VAR_W-1:0]    var_idx_t;
  typedef var_idx_t [NUM_VARS-1:0] dest_t;
  typedef logic [NUM_VARS-1:0] var_mask_t;

  typedef struct packed {
    logic [TABLE_W-1:0] truth_table;
    logic [PERM_W-1:0]  perm_number;
  } request_t;

  typedef struct packed {
    logic [TABLE_W-1:0] permuted_table;
    logic               bad_index;
  } result_t;

  // decoded permutation handed from the decoder to the crossbar
  typedef struct packed {
    logic               bad;
    logic [TABLE_W-1:0] table_bits;
    dest_t              dest;
  } decoded_t;

  // product of the radices below digit position p
  function automatic int perm_divisor(input int p);
    int prod;
    prod = 1;
    for (int q = 0; q < p; q++) begin
      prod = prod * (NUM_VARS - q);
    end
    return prod;
  endfunction

  // index of the digit-th variable not yet taken, ascending
  function automatic var_idx_t pick_var(input var_mask_t used, input var_idx_t digit);
    var_idx_t         idx;
    logic [VAR_W:0]   seen;
    logic             found;
    idx   = '0;
    seen  = '0;
    found = 1'b0;
    for (int v = 0; v < NUM_VARS; v++) begin
      if (!used[v] && !found) begin
        if (seen == {1'b0, digit}) begin
          idx   = VAR_W'(v);
          found = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
    return idx;
  endfunction

endpackage

### design/ttvp_lehmer.sv
// three stage lehmer code decoder: digits, then destinations in two halves
module ttvp_lehmer (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  ttvp_pkg::request_t request,
  output logic              decoded_valid,
  output ttvp_pkg::decoded_t decoded
);
  import ttvp_pkg::*;

  // stage 1: mixed radix digits
  logic               s1_valid;
  logic               s1_bad;
  logic [TABLE_W-1:0] s1_table;
  dest_t              s1_digit;
  dest_t              digit_next;
  logic [PERM_W-1:0]  quot [NUM_VARS+1];

  // quotient by each radix product, through a reciprocal multiply
  assign quot[0] = request.perm_number;
  for (genvar p = 1; p <= NUM_VARS; p++) begin : g_quot
    localparam int Divisor = perm_divisor(p);
    localparam int Recip   = ((1 << RECIP_SHIFT) + Divisor - 1) / Divisor;
    logic [QUOT_W-1:0] prod;
    assign prod    = QUOT_W'(request.perm_number) * QUOT_W'(Recip);
    assign quot[p] = prod[QUOT_W-1:RECIP_SHIFT];
  end

  // digit is what the next quotient leaves over
  for (genvar p = 0; p < NUM_VARS; p++) begin : g_digit
    localparam int Radix = NUM_VARS - p;
    logic [PERM_W-1:0] rem;
    assign rem           = quot[p] - quot[p+1] * PERM_W'(Radix);
    assign digit_next[p] = rem[VAR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= valid;
    end
    s1_bad   <= int'(request.perm_number) >= PERM_COUNT;
    s1_table <= request.truth_table;
    s1_digit <= digit_next;
  end

  // stage 2: first half of the destinations
  logic               s2_valid;
  logic               s2_bad;
  logic [TABLE_W-1:0] s2_table;
  dest_t              s2_digit;
  dest_t              s2_dest;
  var_mask_t          s2_used;
  dest_t              s2_dest_next;
  var_mask_t          s2_used_next;

  always_comb begin
    s2_dest_next = '0;
    s2_used_next = '0;
    for (int p = 0; p < HALF_VARS; p++) begin
      s2_dest_next[p] = pick_var(s2_used_next, s1_digit[p]);
      s2_used_next[s2_dest_next[p]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_bad   <= s1_bad;
    s2_table <= s1_table;
    s2_digit <= s1_digit;
    s2_dest  <= s2_dest_next;
    s2_used  <= s2_used_next;
  end

  // stage 3: remaining destinations
  dest_t     s3_dest_next;
  var_mask_t s3_used;

  always_comb begin
    s3_dest_next = s2_dest;
    s3_used      = s2_used;
    for (int p = HALF_VARS; p < NUM_VARS; p++) begin
      s3_dest_next[p] = pick_var(s3_used, s2_digit[p]);
      s3_used[s3_dest_next[p]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decoded_valid <= 1'b0;
    end else begin
      decoded_valid <= s2_valid;
    end
    decoded.bad        <= s2_bad;
    decoded.table_bits <= s2_table;
    decoded.dest       <= s3_dest_next;
  end

endmodule

### design/ttvp_xbar.sv
// two stage bit crossbar: source index per output bit, then the bit select
module ttvp_xbar (
  input  logic               clk,
  input  logic               rst,
  input  logic               decoded_valid,
  input  ttvp_pkg::decoded_t decoded,
  output logic               done,
  output ttvp_pkg::result_t  result
);
  import ttvp_pkg::*;

  typedef logic [NUM_VARS-1:0] bit_idx_t;

  // stage 4: source assignment for every output bit
  logic               s4_valid;
  logic               s4_bad;
  logic [TABLE_W-1:0] s4_table;
  bit_idx_t           s4_src [TABLE_BITS];
  bit_idx_t           src_next [TABLE_BITS];

  for (genvar i = 0; i < TABLE_BITS; i++) begin : g_src
    localparam bit_idx_t Idx = NUM_VARS'(i);
    for (genvar k = 0; k < NUM_VARS; k++) begin : g_bit
      assign src_next[i][k] = Idx[decoded.dest[k]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= decoded_valid;
    end
    s4_bad   <= decoded.bad;
    s4_table <= decoded.table_bits;
    s4_src   <= src_next;
  end

  // stage 5: select, out of range forces zero
  logic [TABLE_W-1:0] table_next;

  always_comb begin
    table_next = '0;
    for (int i = 0; i < TABLE_BITS; i++) begin
      table_next[i] = s4_table[s4_src[i]] & ~s4_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s4_valid;
    end
    result.permuted_table <= table_next;
    result.bad_index      <= s4_bad;
  end

endmodule

### design/truth_table_variable_permute_top.sv
// top level of the truth table variable permuter
//
// channel   ports                   direction  handshake
// request   start, busy, request    in         taken when start && !busy
// result    done, result            out        one cycle strobe, no back pressure
//
// a request enters every cycle; its result shows on done once it has passed the stages below
// stages: digit extract, two destination-select halves, crossbar index, bit select
// busy is tied low, since the receiver cannot stall nothing ever backs up
// reset clears the valid bits only; payload registers run free
module truth_table_variable_permute_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ttvp_pkg::request_t request,
  output logic               done,
  output ttvp_pkg::result_t  result
);
  import ttvp_pkg::*;

  // link between decoder and crossbar
  logic     decoded_valid;
  decoded_t decoded;

  // pipeline always has room for a new request
  assign busy = 1'b0;

  // lehmer decode: stages one to three
  ttvp_lehmer u_lehmer (
    .clk           (clk),
    .rst           (rst),
    .valid         (start),
    .request       (request),
    .decoded_valid (decoded_valid),
    .decoded       (decoded)
  );

  // variable permutation crossbar: stages four and five
  ttvp_xbar u_xbar (
    .clk           (clk),
    .rst           (rst),
    .decoded_valid (decoded_valid),
    .decoded       (decoded),
    .done          (done),
    .result        (result)
  );

endmodule
